// ===== design/pctd_pkg.sv =====
// ============================================================================
// pctd_pkg
// Shared constants, types and helper functions for the percent decoder.
// ============================================================================
package pctd_pkg;

    // Characters with a special meaning in the encoded stream
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Most decoded words one encoded word can produce
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS + 1);

    // Escape sequence tracking: nothing held, '%' held, '%' and a digit held
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    // Group of decoded words produced by one encoded word
    typedef struct packed {
        logic [IDX_W-1:0]                  cnt;
        logic                              last;
        logic [MAX_RESULTS-1:0][7:0]       data;
    } grp_t;

    // True for 0-9, A-F, a-f
    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
                 ((c >= 8'h41) && (c <= 8'h46)) ||
                 ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Nibble value of a hex digit (don't care for other characters)
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
            v = c - 8'h30;
        else if (c <= 8'h46)
            v = c - 8'h37;
        else
            v = c - 8'h57;
        nibble_of = v[3:0];
    endfunction

    // Plain-text mapping of a character that does not open a sequence
    function automatic logic [7:0] plain_of(input logic [7:0] c);
        plain_of = (c == PLUS_CHAR) ? SPACE_CHAR : c;
    endfunction

endpackage

// ===== design/pctd_if.sv =====
// ============================================================================
// pctd_if
// Valid/ready stream interfaces for the encoded and decoded byte channels.
// ============================================================================

// Encoded byte stream
interface pctd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded byte stream
interface pctd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== design/pctd_decode.sv =====
// ============================================================================
// pctd_decode
// Escape-sequence state and the single-pass decode of one encoded word into
// a group of up to three decoded words.
// ============================================================================
module pctd_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    output pctd_pkg::grp_t grp
);
    import pctd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    // Decode one word against the held sequence
    always_comb
    begin
        logic [IDX_W-1:0] n;
        n          = '0;
        grp.data   = '0;
        phase_next = PH_IDLE;
        held_next  = held_reg;

        unique case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
                else
                begin
                    grp.data[n] = PCT_CHAR;
                    n = n + 1'b1;
                    if (in_byte == PCT_CHAR)
                        phase_next = PH_PCT;
                    else
                    begin
                        grp.data[n] = plain_of(in_byte);
                        n = n + 1'b1;
                    end
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(in_byte))
                begin
                    grp.data[n] = {nibble_of(held_reg), nibble_of(in_byte)};
                    n = n + 1'b1;
                end
                else
                begin
                    // fall back: emit '%', the held digit, then rescan the word
                    grp.data[n] = PCT_CHAR;
                    n = n + 1'b1;
                    grp.data[n] = held_reg;
                    n = n + 1'b1;
                    if (in_byte == PCT_CHAR)
                        phase_next = PH_PCT;
                    else
                    begin
                        grp.data[n] = plain_of(in_byte);
                        n = n + 1'b1;
                    end
                end
            end
            default:
            begin
                if (in_byte == PCT_CHAR)
                    phase_next = PH_PCT;
                else
                begin
                    grp.data[n] = plain_of(in_byte);
                    n = n + 1'b1;
                end
            end
        endcase

        // string ends with a sequence still open: flush it as plain text
        if (in_last)
        begin
            if (phase_next == PH_PCT)
            begin
                grp.data[n] = PCT_CHAR;
                n = n + 1'b1;
            end
            else if (phase_next == PH_DIGIT)
            begin
                grp.data[n] = PCT_CHAR;
                n = n + 1'b1;
                grp.data[n] = held_next;
                n = n + 1'b1;
            end
            phase_next = PH_IDLE;
        end

        grp.cnt  = n;
        grp.last = in_last;
    end

    // Sequence state, updated when the word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== design/pctd_emit.sv =====
// ============================================================================
// pctd_emit
// Result register: holds one decoded group and sends its words one per cycle while dec is ready.
// ============================================================================
module pctd_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  pctd_pkg::grp_t grp,
    output logic           free,
    pctd_out_if.source     dec
);
    import pctd_pkg::*;

    logic                          valid_reg, valid_next;
    logic [IDX_W-1:0]              cnt_reg;
    logic                          last_reg;
    logic [MAX_RESULTS-1:0][7:0]   data_reg;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic                          final_word;
    logic                          done;

    // Output word selection
    assign final_word   = (idx_reg == cnt_reg - 1'b1);
    assign dec.valid    = valid_reg;
    assign dec.out_byte = data_reg[idx_reg[IDX_W-1:0]];
    assign dec.out_last = last_reg && final_word;

    // Group finished this cycle, register free for a new one
    assign done = valid_reg && dec.ready && final_word;
    assign free = !valid_reg || done;

    // Next control state
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (free)
        begin
            valid_next = load;
            idx_next   = '0;
        end
        else if (dec.ready)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            cnt_reg  <= grp.cnt;
            last_reg <= grp.last;
            data_reg <= grp.data;
        end
    end

endmodule

// ===== design/percent_decoder_core.sv =====
// ============================================================================
// percent_decoder_core
// Streaming URL percent decoder, one encoded byte per word.
// ============================================================================
// Usage:
//   enc  - encoded bytes in, in_last marks the final byte of a string.
//   dec  - decoded bytes out, out_last marks the final decoded byte.
//   "%hh" (hex digits in either case) becomes one byte, '+' becomes a space,
//   everything else passes. A broken or truncated sequence is sent as plain
//   text; a byte that breaks one is rescanned and may open a new sequence.
// Timing:
//   An accepted word is held in the input register, is decoded in a single
//   pass and lands in the result register once that register is free, from
//   which its first decoded word is put on dec.
//   Throughput is one word per cycle while each word yields at most one
//   result and dec is ready. A word that yields k results (k up to 3) holds
//   the result register until all k are sent, which is what stalls enc during
//   fallback bursts. A word that only opens or extends a sequence yields
//   nothing and passes straight through. The final word of a string always
//   yields at least one result, so out_last is always sent.
// Reset: clears both valid flags and the held sequence.
// Stall: when dec is not ready the result register holds, the input
//   register still takes one more word, and enc then stalls.
// ============================================================================
module percent_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    pctd_in_if.sink    enc,
    pctd_out_if.source dec
);
    import pctd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       free;
    logic       advance;
    grp_t       grp;

    // Word moves from the input register into the result register
    assign advance   = in_valid_reg && free;
    assign enc.ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (enc.ready)
            in_valid_reg <= enc.valid;
    end

    always_ff @(posedge clk)
    begin
        if (enc.ready && enc.valid)
        begin
            in_byte_reg <= enc.in_byte;
            in_last_reg <= enc.in_last;
        end
    end

    // Decode
    pctd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .grp     (grp)
    );

    // Result register and serializer
    pctd_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && (grp.cnt != '0)),
        .grp   (grp),
        .free  (free),
        .dec   (dec)
    );

endmodule
